FILE: sv/mfap_pkg.sv
package mfap_pkg;

   localparam int NODES     = 16;
   localparam int NODE_BITS = 4;
   localparam int CAP_BITS  = 24;
   localparam int RES_BITS  = CAP_BITS + 1;
   localparam int FLOW_BITS = 28;
   localparam int EDGE_BITS = 16;
   localparam int ADDR_BITS = 2 * NODE_BITS;
   localparam int CELLS     = NODES * NODES;
   localparam int PTR_BITS  = NODE_BITS + 1;

   localparam logic [RES_BITS-1:0]  CAP_MAX  = {1'b0, {CAP_BITS{1'b1}}};
   localparam logic [RES_BITS-1:0]  RES_MAX  = {RES_BITS{1'b1}};
   localparam logic [FLOW_BITS-1:0] FLOW_MAX = {FLOW_BITS{1'b1}};

   localparam logic [1:0] MODE_ADD   = 2'd0;
   localparam logic [1:0] MODE_RUN   = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_RUN   = 2'd1,
      OP_SAME  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic [NODE_BITS-1:0]   src;
      logic [NODE_BITS-1:0]   dst;
      logic [EDGE_BITS-1:0]   cap;
   } cmd_type;

endpackage

FILE: sv/max_flow_augmenting_path_core.sv
// add: a read and a write state; clear: valid bits drop in idle; all pass the queue first
// run: a seed step per search, a read and check per unvisited neighbor probed, a top step
// per visited neighbor skipped or per pop, a min walk and a residual update per path edge
// and an end step. throughput: one beat per cycle while the two-entry queue has room;
// a run waits until the previous reply is taken; single store port sets all
// reset: queue, response slot and store valid bits cleared at once, no clearing pass
module max_flow_augmenting_path_core import mfap_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_mode,
   input  logic [NODE_BITS-1:0] req_from_node,
   input  logic [NODE_BITS-1:0] req_to_node,
   input  logic [EDGE_BITS-1:0] req_edge_capacity,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [FLOW_BITS-1:0] rsp_max_flow,
   output logic                 rsp_status
);

   // front to queue
   logic    push;
   cmd_type push_cmd;
   logic    queue_full;

   // queue to back end
   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type head;

   // front: takes each beat unless the queue is full, classifies mode, drops the unused mode code
   mfap_front u_front (
      .req_valid         (req_valid),
      .req_mode          (req_mode),
      .req_from_node     (req_from_node),
      .req_to_node       (req_to_node),
      .req_edge_capacity (req_edge_capacity),
      .queue_full        (queue_full),
      .req_stall         (req_stall),
      .push              (push),
      .cmd               (push_cmd)
   );

   // short queue decouples intake from the long-running search
   mfap_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (cmd_pop),
      .full      (queue_full),
      .not_empty (cmd_valid),
      .head      (head)
   );

   // back end: residual store, depth-first search, path update, reply register
   mfap_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (cmd_valid),
      .cmd          (head),
      .cmd_pop      (cmd_pop),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_max_flow (rsp_max_flow),
      .rsp_status   (rsp_status)
   );

endmodule

FILE: sv/mfap_ram.sv
module mfap_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/mfap_front.sv
module mfap_front import mfap_pkg::*; (
   input  logic                 req_valid,
   input  logic [1:0]           req_mode,
   input  logic [NODE_BITS-1:0] req_from_node,
   input  logic [NODE_BITS-1:0] req_to_node,
   input  logic [EDGE_BITS-1:0] req_edge_capacity,
   input  logic                 queue_full,
   output logic                 req_stall,
   output logic                 push,
   output cmd_type              cmd
);

   assign req_stall = queue_full;

   always_comb begin
      cmd.src = req_from_node;
      cmd.dst = req_to_node;
      cmd.cap = req_edge_capacity;
      cmd.op  = OP_ADD;
      push    = 1'b0;
      case (req_mode)
         MODE_ADD: begin
            cmd.op = OP_ADD;
            push   = req_valid && !queue_full;
         end
         MODE_RUN: begin
            // source equal to sink gets its error reply without a search
            cmd.op = (req_from_node == req_to_node) ? OP_SAME : OP_RUN;
            push   = req_valid && !queue_full;
         end
         MODE_CLEAR: begin
            cmd.op = OP_CLEAR;
            push   = req_valid && !queue_full;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

endmodule

FILE: sv/mfap_queue.sv
module mfap_queue import mfap_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    not_empty,
   output cmd_type head
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: sv/mfap_engine.sv
module mfap_engine import mfap_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   input  cmd_type              cmd,
   output logic                 cmd_pop,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output logic [FLOW_BITS-1:0] rsp_max_flow,
   output logic                 rsp_status
);

   typedef enum logic [11:0] {
      S_IDLE    = 12'b000000000001,
      S_ADD_RD  = 12'b000000000010,
      S_ADD_WR  = 12'b000000000100,
      S_INIT    = 12'b000000001000,
      S_TOP     = 12'b000000010000,
      S_CHK     = 12'b000000100000,
      S_MIN_RD  = 12'b000001000000,
      S_MIN_CHK = 12'b000010000000,
      S_UPD_RF  = 12'b000100000000,
      S_UPD_RB  = 12'b001000000000,
      S_UPD_WF  = 12'b010000000000,
      S_UPD_WB  = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;

   logic [NODE_BITS-1:0] src_ff, src_in, dst_ff, dst_in;
   logic [EDGE_BITS-1:0] cap_ff, cap_in;
   logic [FLOW_BITS-1:0] total_ff, total_in;
   logic [RES_BITS-1:0]  path_ff, path_in;
   logic [RES_BITS-1:0]  fwd_ff, fwd_in;
   logic [RES_BITS-1:0]  back_ff, back_in;
   logic [PTR_BITS-1:0]  sp_ff, sp_in;
   logic [NODE_BITS-1:0] stack_ff [NODES];
   logic [NODE_BITS-1:0] stack_in [NODES];
   logic [PTR_BITS-1:0]  next_ff [NODES];
   logic [PTR_BITS-1:0]  next_in [NODES];
   logic [NODE_BITS-1:0] parent_ff [NODES];
   logic [NODE_BITS-1:0] parent_in [NODES];
   logic [NODES-1:0]     visited_ff, visited_in;
   logic [NODE_BITS-1:0] u_ff, u_in, v_ff, v_in, walk_ff, walk_in;
   logic [CELLS-1:0]     vld_ff, vld_in;
   logic [ADDR_BITS-1:0] rd_addr, rd_addr_ff;
   logic                 wr_en;
   logic [ADDR_BITS-1:0] wr_addr;
   logic [RES_BITS-1:0]  wr_data;
   logic [RES_BITS-1:0]  ram_q, rd_eff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [FLOW_BITS-1:0] rsp_flow_ff, rsp_flow_in;
   logic                 rsp_status_ff, rsp_status_in;

   logic [NODE_BITS-1:0] top_u, par_u;
   logic [PTR_BITS-1:0]  top_next;
   logic [PTR_BITS-1:0]  sp_dec;
   logic [RES_BITS:0]    add_sum, back_sum;
   logic [FLOW_BITS:0]   flow_sum;

   mfap_ram #(.WIDTH(RES_BITS), .DEPTH(CELLS)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // never-written cells read as zero
   assign rd_eff = vld_ff[rd_addr_ff] ? ram_q : '0;

   assign sp_dec   = sp_ff - PTR_BITS'(1);
   assign top_u    = stack_ff[sp_dec[NODE_BITS-1:0]];
   assign top_next = next_ff[top_u];
   assign par_u    = parent_ff[walk_ff];
   assign add_sum  = {1'b0, rd_eff} + {{(RES_BITS+1-EDGE_BITS){1'b0}}, cap_ff};
   assign back_sum = {1'b0, rd_eff} + {1'b0, path_ff};
   assign flow_sum = {1'b0, total_ff} + {{(FLOW_BITS+1-RES_BITS){1'b0}}, path_ff};

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_max_flow = rsp_flow_ff;
   assign rsp_status   = rsp_status_ff;

   always_comb begin
      state_in      = state_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      cap_in        = cap_ff;
      total_in      = total_ff;
      path_in       = path_ff;
      fwd_in        = fwd_ff;
      back_in       = back_ff;
      sp_in         = sp_ff;
      stack_in      = stack_ff;
      next_in       = next_ff;
      parent_in     = parent_ff;
      visited_in    = visited_ff;
      u_in          = u_ff;
      v_in          = v_ff;
      walk_in       = walk_ff;
      vld_in        = vld_ff;
      rd_addr       = rd_addr_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      cmd_pop       = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_flow_in   = rsp_flow_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         S_IDLE: begin
            // adds and clears never reply, so a waiting reply only holds back runs
            if (cmd_valid && (!rsp_valid_ff || cmd.op == OP_ADD || cmd.op == OP_CLEAR)) begin
               cmd_pop = 1'b1;
               src_in  = cmd.src;
               dst_in  = cmd.dst;
               cap_in  = cmd.cap;
               case (cmd.op)
                  OP_ADD: begin
                     rd_addr  = {cmd.src, cmd.dst};
                     state_in = S_ADD_RD;
                  end
                  OP_RUN: begin
                     total_in = '0;
                     state_in = S_INIT;
                  end
                  OP_SAME: begin
                     rsp_valid_in  = 1'b1;
                     rsp_flow_in   = '0;
                     rsp_status_in = 1'b1;
                  end
                  OP_CLEAR: begin
                     vld_in = '0;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_ADD_RD: begin
            state_in = S_ADD_WR;
         end
         S_ADD_WR: begin
            if (rd_eff < CAP_MAX) begin
               wr_en   = 1'b1;
               wr_addr = {src_ff, dst_ff};
               wr_data = (add_sum > {1'b0, CAP_MAX}) ? CAP_MAX : add_sum[RES_BITS-1:0];
               vld_in[wr_addr] = 1'b1;
            end
            state_in = S_IDLE;
         end
         S_INIT: begin
            visited_in         = '0;
            visited_in[src_ff] = 1'b1;
            stack_in[0]        = src_ff;
            sp_in              = PTR_BITS'(1);
            next_in[src_ff]    = '0;
            state_in           = S_TOP;
         end
         S_TOP: begin
            if (sp_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_flow_in   = total_ff;
               rsp_status_in = 1'b0;
               state_in      = S_IDLE;
            end else if (top_u == dst_ff) begin
               walk_in  = dst_ff;
               path_in  = RES_MAX;
               state_in = S_MIN_RD;
            end else if (top_next[NODE_BITS]) begin
               sp_in = sp_dec;
            end else if (visited_ff[top_next[NODE_BITS-1:0]]) begin
               next_in[top_u] = top_next + PTR_BITS'(1);
            end else begin
               u_in     = top_u;
               v_in     = top_next[NODE_BITS-1:0];
               rd_addr  = {top_u, top_next[NODE_BITS-1:0]};
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            next_in[u_ff] = {1'b0, v_ff} + PTR_BITS'(1);
            if (rd_eff != '0) begin
               parent_in[v_ff]                 = u_ff;
               visited_in[v_ff]                = 1'b1;
               next_in[v_ff]                   = '0;
               stack_in[sp_ff[NODE_BITS-1:0]]  = v_ff;
               sp_in                           = sp_ff + PTR_BITS'(1);
            end
            state_in = S_TOP;
         end
         S_MIN_RD: begin
            u_in     = par_u;
            rd_addr  = {par_u, walk_ff};
            state_in = S_MIN_CHK;
         end
         S_MIN_CHK: begin
            if (rd_eff < path_ff) begin
               path_in = rd_eff;
            end
            if (u_ff == src_ff) begin
               walk_in  = dst_ff;
               state_in = S_UPD_RF;
            end else begin
               walk_in  = u_ff;
               state_in = S_MIN_RD;
            end
         end
         S_UPD_RF: begin
            u_in     = par_u;
            rd_addr  = {par_u, walk_ff};
            state_in = S_UPD_RB;
         end
         S_UPD_RB: begin
            // forward read lands now
            fwd_in   = rd_eff;
            rd_addr  = {walk_ff, u_ff};
            state_in = S_UPD_WF;
         end
         S_UPD_WF: begin
            // reverse read lands now
            wr_en   = 1'b1;
            wr_addr = {u_ff, walk_ff};
            wr_data = fwd_ff - path_ff;
            vld_in[wr_addr] = 1'b1;
            back_in  = (back_sum > {1'b0, RES_MAX}) ? RES_MAX : back_sum[RES_BITS-1:0];
            state_in = S_UPD_WB;
         end
         S_UPD_WB: begin
            wr_en   = 1'b1;
            wr_addr = {walk_ff, u_ff};
            wr_data = back_ff;
            vld_in[wr_addr] = 1'b1;
            if (u_ff == src_ff) begin
               total_in = (flow_sum > {1'b0, FLOW_MAX}) ? FLOW_MAX
                                                        : flow_sum[FLOW_BITS-1:0];
               state_in = S_INIT;
            end else begin
               walk_in  = u_ff;
               state_in = S_UPD_RF;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         vld_ff       <= '0;
         visited_ff   <= '0;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vld_ff       <= vld_in;
         visited_ff   <= visited_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      cap_ff        <= cap_in;
      total_ff      <= total_in;
      path_ff       <= path_in;
      fwd_ff        <= fwd_in;
      back_ff       <= back_in;
      stack_ff      <= stack_in;
      next_ff       <= next_in;
      parent_ff     <= parent_in;
      u_ff          <= u_in;
      v_ff          <= v_in;
      walk_ff       <= walk_in;
      rd_addr_ff    <= rd_addr;
      rsp_flow_ff   <= rsp_flow_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

FILE: sv/mfap_checker.sv
module mfap_checker import mfap_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic [1:0]           req_mode,
   input logic [NODE_BITS-1:0] req_from_node,
   input logic [NODE_BITS-1:0] req_to_node,
   input logic [EDGE_BITS-1:0] req_edge_capacity,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [FLOW_BITS-1:0] rsp_max_flow,
   input logic                 rsp_status
);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_mode) && $stable(req_from_node)
         && $stable(req_to_node) && $stable(req_edge_capacity))
      else $error("req beat changed while stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_max_flow) && $stable(rsp_status))
      else $error("rsp payload changed while stalled");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_max_flow == '0)
      else $error("error reply carries nonzero flow");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind max_flow_augmenting_path_core mfap_checker u_mfap_checker (.*);
